>>> hw/rtl/addressable_led_frame_driver_macros.svh
// Assertion macros for the addressable LED frame driver.
// Included by the top level; no other dependencies.
`ifndef ADDRESSABLE_LED_FRAME_DRIVER_MACROS_SVH
`define ADDRESSABLE_LED_FRAME_DRIVER_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset
`define ALFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define ALFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALFD_ASSERT(label, clk, rst_n, prop, msg)
`define ALFD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/aled_pkg.sv
// Shared types and constants for the addressable LED frame driver.
// No dependencies.
package aled_pkg;

  // Input command codes
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_BAR   = 3'd1;
  localparam logic [2:0] CMD_MOVE  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_SEND  = 3'd4;

  // Decoded operation codes, front to back
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_BAR   = 3'd2;
  localparam logic [2:0] OP_MOVE  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_SEND  = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_IDX_RANGE = 2'd1;
  localparam logic [1:0] STATUS_PCT_RANGE = 2'd2;

  // Configuration register indexes and reset values
  localparam logic CFG_ONE_PATTERN  = 1'b0;
  localparam logic CFG_ZERO_PATTERN = 1'b1;
  localparam logic [7:0] ONE_PATTERN_RST  = 8'hF8;
  localparam logic [7:0] ZERO_PATTERN_RST = 8'hE0;

  // Bargraph limit and reciprocal scaling shift
  localparam logic [7:0] PCT_MAX   = 8'd100;
  localparam int         BAR_SHIFT = 14;

  // Last bit of one pixel in the serial stream (24 bits, GRB)
  localparam logic [4:0] PIX_BIT_LAST = 5'd23;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] status;
    logic [7:0] led;
    logic [7:0] full;
    logic       half;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pulse_byte;
    logic       byte_valid;
    logic       frame_last;
  } res_t;

  // Number of LEDs a bargraph writes: whole ones plus an optional half one
  function automatic logic [7:0] bar_len(input op_t o);
    bar_len = o.full + {7'd0, o.half};
  endfunction

endpackage

>>> hw/rtl/aled_fifo.sv
// Small synchronous queue used between front and back and on the result side.
// No package dependencies.
module aled_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/aled_front.sv
// Front end: accepts items, checks ranges and decodes them into operations.
// Depends on aled_pkg.
module aled_front import aled_pkg::*; #(
  parameter int LED_COUNT = 8
) (
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_led_index,
  input  logic [7:0] in_percentage,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       op_full,
  output logic       op_push,
  output op_t        op
);
  // points = 2*LED_COUNT*pct/100 as one multiply by a scaled reciprocal
  localparam logic [15:0] BAR_MUL =
    16'((((2 * LED_COUNT) << BAR_SHIFT) + 99) / 100);

  logic [23:0] bar_prod;
  logic [7:0]  points;

  assign in_full  = op_full;
  assign op_push  = in_push && !op_full;
  assign bar_prod = {16'd0, in_percentage} * {8'd0, BAR_MUL};
  assign points   = bar_prod[BAR_SHIFT +: 8];

  // Decode and range checks
  always_comb begin
    op        = '0;
    op.led    = in_led_index;
    op.full   = {1'b0, points[7:1]};
    op.half   = points[0];
    op.red    = in_red;
    op.green  = in_green;
    op.blue   = in_blue;
    op.op     = OP_NOP;
    op.status = STATUS_OK;
    case (in_cmd)
      CMD_WRITE: begin
        if (in_led_index < 8'(LED_COUNT)) begin
          op.op = OP_WRITE;
        end else begin
          op.status = STATUS_IDX_RANGE;
        end
      end
      CMD_BAR: begin
        if (in_percentage > PCT_MAX) begin
          op.status = STATUS_PCT_RANGE;
        end else begin
          op.op = OP_BAR;
        end
      end
      CMD_MOVE:  op.op = OP_MOVE;
      CMD_CLEAR: op.op = OP_CLEAR;
      CMD_SEND:  op.op = OP_SEND;
      default:   op.op = OP_NOP;
    endcase
  end

endmodule

>>> hw/rtl/aled_back.sv
// Back end: pixel memory, sequencer for store updates and the bit serializer.
// Depends on aled_pkg.
module aled_back import aled_pkg::*; #(
  parameter int LED_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  op_t        op_in,
  input  logic       op_empty,
  output logic       op_pop,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res
);
  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_MOVE_ON  = 2'd1;
  localparam logic [1:0] S_BAR_FILL = 2'd2;
  localparam logic [1:0] S_SEND_SEL = 2'd3;

  logic [1:0]       state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] mov_pos_r, mov_pos_nxt;
  logic [IDX_W-1:0] send_led_r, send_led_nxt;
  logic [4:0]       send_bit_r, send_bit_nxt;
  logic [7:0]       one_pat_r;
  logic [7:0]       zero_pat_r;

  logic [23:0]          pix_mem [LED_COUNT];
  logic [LED_COUNT-1:0] valid_r;
  logic [23:0]          rd_data_r;
  logic                 rd_vld_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [23:0]      wr_data;
  logic             clr_all;
  logic             rd_en;
  logic [IDX_W-1:0] mov_prev;
  logic [IDX_W-1:0] mov_next;
  logic [23:0]      pix_sel;
  logic             pix_bit;
  logic [7:0]       cnt_ext;
  logic [7:0]       cnt_inc;

  assign mov_prev = (mov_pos_r == '0) ? IDX_LAST : mov_pos_r - 1'b1;
  assign mov_next = (mov_pos_r == IDX_LAST) ? '0 : mov_pos_r + 1'b1;
  assign pix_sel  = rd_vld_r ? rd_data_r : '0;
  assign pix_bit  = pix_sel[PIX_BIT_LAST - send_bit_r];
  assign cnt_ext  = 8'(cnt_r);
  assign cnt_inc  = cnt_ext + 8'd1;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    mov_pos_nxt  = mov_pos_r;
    send_led_nxt = send_led_r;
    send_bit_nxt = send_bit_r;
    wr_en        = 1'b0;
    wr_addr      = cnt_r;
    wr_data      = '0;
    clr_all      = 1'b0;
    rd_en        = 1'b0;
    op_pop       = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    case (state_r)
      S_IDLE: begin
        // A result slot is free before an item is started
        if (!op_empty && !res_full) begin
          op_pop     = 1'b1;
          op_nxt     = op_in;
          res.status = op_in.status;
          case (op_in.op)
            OP_WRITE: begin
              wr_en    = 1'b1;
              wr_addr  = op_in.led[IDX_W-1:0];
              wr_data  = {op_in.green, op_in.red, op_in.blue};
              res_push = 1'b1;
            end
            OP_CLEAR: begin
              clr_all  = 1'b1;
              res_push = 1'b1;
            end
            OP_MOVE: begin
              wr_en     = 1'b1;
              wr_addr   = mov_prev;
              state_nxt = S_MOVE_ON;
            end
            OP_BAR: begin
              clr_all = 1'b1;
              cnt_nxt = '0;
              if (bar_len(op_in) == 8'd0) begin
                res_push = 1'b1;
              end else begin
                state_nxt = S_BAR_FILL;
              end
            end
            OP_SEND: begin
              rd_en     = 1'b1;
              state_nxt = S_SEND_SEL;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      S_MOVE_ON: begin
        wr_en       = 1'b1;
        wr_addr     = mov_pos_r;
        wr_data     = {op_r.green, op_r.red, op_r.blue};
        mov_pos_nxt = mov_next;
        res_push    = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_BAR_FILL: begin
        // Whole LEDs at full color, the odd half point at half color
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        if (cnt_ext == op_r.full) begin
          wr_data = {1'b0, op_r.green[7:1], 1'b0, op_r.red[7:1], 1'b0, op_r.blue[7:1]};
        end else begin
          wr_data = {op_r.green, op_r.red, op_r.blue};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_inc == bar_len(op_r)) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SEND_SEL: begin
        res.pulse_byte = pix_bit ? one_pat_r : zero_pat_r;
        res.byte_valid = 1'b1;
        if (send_bit_r == PIX_BIT_LAST) begin
          send_bit_nxt = '0;
          if (send_led_r == IDX_LAST) begin
            res.frame_last = 1'b1;
            send_led_nxt   = '0;
          end else begin
            send_led_nxt = send_led_r + 1'b1;
          end
        end else begin
          send_bit_nxt = send_bit_r + 1'b1;
        end
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mov_pos_r  <= '0;
      send_led_r <= '0;
      send_bit_r <= '0;
    end else begin
      state_r    <= state_nxt;
      mov_pos_r  <= mov_pos_nxt;
      send_led_r <= send_led_nxt;
      send_bit_r <= send_bit_nxt;
    end
  end

  // Operation operands and bargraph counter
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_pat_r  <= ONE_PATTERN_RST;
      zero_pat_r <= ZERO_PATTERN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ONE_PATTERN:  one_pat_r  <= cfg_data;
        CFG_ZERO_PATTERN: zero_pat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-LED valid bits; an invalid entry reads as off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (clr_all) begin
        valid_r <= '0;
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Pixel memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= pix_mem[send_led_r];
      rd_vld_r  <= valid_r[send_led_r];
    end
  end

endmodule

>>> hw/rtl/addressable_led_frame_driver.sv
// Top level of the addressable LED frame driver: front, queues and back end.
// Depends on aled_pkg, aled_fifo, aled_front, aled_back and the macros header.
//
//   channel  | ports                                     | handshake
//   ---------+-------------------------------------------+------------------------
//   input    | in_cmd, in_led_index, in_percentage, RGB  | in_push / in_full
//   result   | out_status, out_pulse_byte, out_byte_...  | out_pop / out_empty
//   config   | cfg_index, cfg_data                       | cfg_we, no wait
//
// An item passes the op queue, then the back-end sequencer: write, clear and errors
// finish in S_IDLE, moving point and next byte (memory read) go on to S_MOVE_ON or
// S_SEND_SEL, and a bargraph writes its full + half LEDs in S_BAR_FILL, at most LED_COUNT.
// Reset is synchronous and clears the pixel valid bits at once, no sweep.
// A full result queue holds the sequencer; the front keeps queueing items until the op queue is full.
`include "addressable_led_frame_driver_macros.svh"
module addressable_led_frame_driver import aled_pkg::*; #(
  parameter int LED_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_led_index,
  input  logic [7:0] in_percentage,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_status,
  output logic [7:0] out_pulse_byte,
  output logic       out_byte_valid,
  output logic       out_frame_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  op_t  op_wr;
  op_t  op_rd;
  logic op_push;
  logic op_full;
  logic op_empty;
  logic op_pop;
  res_t res_wr;
  res_t res_rd;
  logic res_push;
  logic res_full;

  // Decode
  aled_front #(.LED_COUNT(LED_COUNT)) u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_led_index (in_led_index),
    .in_percentage(in_percentage),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .op_full      (op_full),
    .op_push      (op_push),
    .op           (op_wr)
  );

  // Operation queue between front and back
  aled_fifo #(.WIDTH($bits(op_t)), .AW(1)) u_op_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (op_push),
    .wdata(op_wr),
    .full (op_full),
    .pop  (op_pop),
    .rdata(op_rd),
    .empty(op_empty)
  );

  // Execution
  aled_back #(.LED_COUNT(LED_COUNT)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .op_in    (op_rd),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_wr)
  );

  // Result queue
  aled_fifo #(.WIDTH($bits(res_t)), .AW(1)) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_wr),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_rd),
    .empty(out_empty)
  );

  assign out_status     = res_rd.status;
  assign out_pulse_byte = res_rd.pulse_byte;
  assign out_byte_valid = res_rd.byte_valid;
  assign out_frame_last = res_rd.frame_last;

  // Checks
  `ALFD_ASSERT(a_op_pop_nonempty, clk, rst_n, op_pop |-> !op_empty, "op taken from empty queue")
  `ALFD_ASSERT(a_res_no_overflow, clk, rst_n, res_push |-> !res_full, "result pushed into full queue")
  `ALFD_ASSERT(a_start_has_room, clk, rst_n, op_pop |-> !res_full, "item started with no result slot")
  `ALFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty && !in_full, "queues not empty after reset")

endmodule

>>> bench/aled_frame_checker.sv
`timescale 1ns / 100ps
// Checker for the addressable LED frame driver. It mirrors the pixel store, the moving
// point and the pulse serializer, and compares every popped reply with its prediction.
// Depends on aled_pkg.
module aled_frame_checker import aled_pkg::*; #(
  parameter int LED_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_led_index,
  input  logic [7:0] in_percentage,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [1:0] out_status,
  input  logic [7:0] out_pulse_byte,
  input  logic       out_byte_valid,
  input  logic       out_frame_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         fault_count,
  output int         replies_owed
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Mirror of the block state
  pixel_t     pixels [LED_COUNT];
  logic [7:0] move_pos;
  logic [7:0] send_led;
  logic [4:0] send_bit;
  logic [7:0] one_pat;
  logic [7:0] zero_pat;

  res_t reply_q [$];
  int   faults;

  function automatic void wipe_pixels();
    int i;
    for (i = 0; i < LED_COUNT; i++) pixels[i] = '0;
  endfunction

  // Applies one command to the mirrored state and returns the reply it produces
  function automatic res_t predict_led_reply(input logic [2:0] cmd, input logic [7:0] idx,
                                             input logic [7:0] pct, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
    res_t       rep;
    int         points;
    int         i;
    logic [7:0] prev;
    logic [7:0] chan;
    pixel_t     px;
    rep = '0;
    case (cmd)
      CMD_WRITE: begin
        if (idx < LED_COUNT) pixels[idx] = {r, g, b};
        else rep.status = STATUS_IDX_RANGE;
      end
      CMD_BAR: begin
        if (pct > PCT_MAX) begin
          rep.status = STATUS_PCT_RANGE;
        end else begin
          // two points per LED; an odd point lights one LED at half level
          points = (2 * LED_COUNT * int'(pct)) / int'(PCT_MAX);
          wipe_pixels();
          for (i = 0; i < points / 2; i++) pixels[i] = {r, g, b};
          if (points % 2 != 0) pixels[points / 2] = {r >> 1, g >> 1, b >> 1};
        end
      end
      CMD_MOVE: begin
        prev = (move_pos == 0) ? 8'(LED_COUNT - 1) : move_pos - 8'd1;
        pixels[prev]     = '0;
        pixels[move_pos] = {r, g, b};
        move_pos = (move_pos + 1 == LED_COUNT) ? 8'd0 : move_pos + 8'd1;
      end
      CMD_CLEAR: wipe_pixels();
      CMD_SEND: begin
        // GRB order, MSB first
        px = pixels[send_led];
        if (send_bit < 8) chan = px.green;
        else if (send_bit < 16) chan = px.red;
        else chan = px.blue;
        rep.pulse_byte = chan[7 - send_bit[2:0]] ? one_pat : zero_pat;
        rep.byte_valid = 1'b1;
        if (send_bit == PIX_BIT_LAST) begin
          send_bit = '0;
          if (send_led == LED_COUNT - 1) begin
            rep.frame_last = 1'b1;
            send_led = '0;
          end else begin
            send_led = send_led + 8'd1;
          end
        end else begin
          send_bit = send_bit + 5'd1;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (!rst_n) begin
      wipe_pixels();
      move_pos = '0;
      send_led = '0;
      send_bit = '0;
      one_pat  = ONE_PATTERN_RST;
      zero_pat = ZERO_PATTERN_RST;
      reply_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ONE_PATTERN) one_pat = cfg_data;
        else zero_pat = cfg_data;
      end
      if (in_push && !in_full)
        reply_q.push_back(predict_led_reply(in_cmd, in_led_index, in_percentage,
                                            in_red, in_green, in_blue));
      if (out_pop && !out_empty) begin
        got = '{out_status, out_pulse_byte, out_byte_valid, out_frame_last};
        if (reply_q.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("%0t: unexpected reply status %0d pulse %02h valid %b last %b",
                     $realtime, got.status, got.pulse_byte, got.byte_valid, got.frame_last);
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status || got.pulse_byte !== want.pulse_byte ||
              got.byte_valid !== want.byte_valid || got.frame_last !== want.frame_last) begin
            faults++;
            if (faults <= REPORT_LIMIT)
              $display("%0t: reply mismatch: want status %0d pulse %02h valid %b last %b, %s",
                       $realtime, want.status, want.pulse_byte, want.byte_valid,
                       want.frame_last,
                       $sformatf("got status %0d pulse %02h valid %b last %b",
                                 got.status, got.pulse_byte, got.byte_valid,
                                 got.frame_last));
          end
        end
      end
    end
    fault_count  <= faults;
    replies_owed <= reply_q.size();
  end

endmodule

>>> bench/tb_addressable_led_frame_driver.sv
`timescale 1ns / 100ps
// Top of the LED frame driver bench: clock, reset, command traffic, pop pacing and verdict.
// Depends on aled_pkg, addressable_led_frame_driver and aled_frame_checker.
module tb_addressable_led_frame_driver;
  import aled_pkg::*;

  localparam int LED_COUNT   = 8;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 225;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 2 * LED_COUNT + 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [2:0] in_cmd = '0;
  logic [7:0] in_led_index = '0;
  logic [7:0] in_percentage = '0;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_pulse_byte;
  logic       out_byte_valid;
  logic       out_frame_last;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_ONE_PATTERN;
  logic [7:0] cfg_data = '0;

  int   fault_count;
  int   replies_owed;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_armed = 1'b0;
  int   hold_done = 0;
  int   cycles = 0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  addressable_led_frame_driver #(.LED_COUNT(LED_COUNT)) u_top (.*);

  aled_frame_checker #(.LED_COUNT(LED_COUNT)) u_checker (.*);

  // Pop pacing; a one-time long hold-off lets the block back up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_armed && hold_done < HOLD_CYCLES) begin
      out_pop   <= 1'b0;
      hold_done <= hold_done + 1;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it
  task automatic offer_item(input logic [2:0] cmd, input logic [7:0] idx,
                            input logic [7:0] pct, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_cmd        <= cmd;
    in_led_index  <= idx;
    in_percentage <= pct;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Serializer traffic for half the items, so frames wrap several times, with edits in between
  task automatic offer_random_item();
    int         pick;
    logic [2:0] cmd;
    logic [7:0] idx;
    logic [7:0] pct;
    pick = $urandom_range(99);
    if (pick < 50) cmd = CMD_SEND;
    else if (pick < 64) cmd = CMD_WRITE;
    else if (pick < 76) cmd = CMD_MOVE;
    else if (pick < 88) cmd = CMD_BAR;
    else if (pick < 94) cmd = CMD_CLEAR;
    else cmd = 3'(int'(CMD_SEND) + 1 + $urandom_range(2));
    idx = ($urandom_range(3) != 0) ? 8'($urandom_range(LED_COUNT - 1)) : 8'($urandom_range(255));
    pct = ($urandom_range(5) != 0) ? 8'($urandom_range(int'(PCT_MAX)))
                                   : 8'($urandom_range(255, int'(PCT_MAX) + 1));
    offer_item(cmd, idx, pct, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stop offering and wait for every reply to come back
  task automatic drain_replies();
    in_push <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_patterns(input logic [7:0] one_val, input logic [7:0] zero_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ONE_PATTERN;
    cfg_data  <= one_val;
    @(posedge clk);
    cfg_index <= CFG_ZERO_PATTERN;
    cfg_data  <= zero_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] one_set  [PHASES];
    logic [7:0] zero_set [PHASES];
    int         ph;
    int         k;
    one_set  = '{8'hFF, 8'h00, 8'h80, 8'hC3, 8'hF8, 8'h5A};
    zero_set = '{8'h00, 8'hFF, 8'h00, 8'h3C, 8'hE0, 8'hA5};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: index edges, bargraph limits and half LED, moving point wrap, odd codes
    offer_item(CMD_WRITE, 8'd0, 8'd0, 8'hFF, 8'h00, 8'hA5);
    offer_item(CMD_WRITE, 8'(LED_COUNT - 1), 8'hFF, 8'h00, 8'hFF, 8'h5A);
    offer_item(CMD_WRITE, 8'(LED_COUNT), 8'd0, 8'h12, 8'h34, 8'h56);
    offer_item(CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_item(CMD_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    offer_item(CMD_BAR, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    offer_item(CMD_BAR, 8'd0, PCT_MAX, 8'hFF, 8'hFF, 8'hFF);
    offer_item(CMD_BAR, 8'd0, PCT_MAX + 8'd1, 8'h11, 8'h22, 8'h33);
    offer_item(CMD_BAR, 8'd0, 8'hFF, 8'h11, 8'h22, 8'h33);
    offer_item(CMD_BAR, 8'd0, 8'd7, 8'hFF, 8'h81, 8'h7F);
    offer_item(CMD_BAR, 8'd0, 8'd69, 8'h0F, 8'hF0, 8'h01);
    for (k = 0; k <= LED_COUNT; k++)
      offer_item(CMD_MOVE, 8'd0, 8'd0, 8'(k * 31), 8'hFF - 8'(k), 8'(k + 1));
    offer_item(CMD_SEND, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    for (k = int'(CMD_SEND) + 1; k < 8; k++)
      offer_item(3'(k), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // Random phases, each under its own pulse patterns and pacing
    for (ph = 0; ph < PHASES; ph++) begin
      drain_replies();
      program_patterns(one_set[ph], zero_set[ph]);
      case (ph)
        0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct <= 55; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct <= 0;  rx_stall_pct <= 55; end
        3: begin tx_idle_pct <= 12; rx_stall_pct <= 12; end
        4: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  hold_armed <= 1'b1; end
        default: begin tx_idle_pct <= 55; rx_stall_pct <= 55; end
      endcase
      @(posedge clk);
      repeat (PHASE_ITEMS) offer_random_item();
    end

    drain_replies();
    if (fault_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/aled_pkg.sv
hw/rtl/aled_fifo.sv
hw/rtl/aled_front.sv
hw/rtl/aled_back.sv
hw/rtl/addressable_led_frame_driver.sv
bench/aled_frame_checker.sv
bench/tb_addressable_led_frame_driver.sv
